/* hdl/tsl_pkg.sv */
// Package for the triplet softplus loss block: payload types, constants, softplus table.
// No dependencies.
package tsl_pkg;

	localparam int unsigned MaxTripletsDefault = 1024;
	localparam int unsigned MaxDimDefault = 4096;
	localparam logic [15:0] InvMarginReset = 16'd256;
	localparam logic [47:0] AccMax = {48{1'b1}};

	typedef struct packed {
		logic signed [15:0] anchor_value;
		logic signed [15:0] positive_value;
		logic signed [15:0] negative_value;
		logic               last_of_triplet;
		logic               last_of_batch;
	} in_item_t;

	typedef struct packed {
		logic [31:0] loss_first;
		logic [31:0] loss_second;
		logic [31:0] batch_loss;
		logic        batch_done;
	} out_item_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accum;     // add squares of accepted item
		logic arg_first; // compute arg for dn1
		logic arg_second;// compute arg for dn2
		logic sp_first;  // softplus of registered arg into loss_first
		logic sp_second; // softplus of registered arg into loss_second
		logic close;     // clear distance accumulators, add losses to total
		logic div_start; // load divider
		logic div_step;  // one quotient bit
		logic batch_clr; // clear total and count
	} tsl_cmd_t;

	typedef struct packed {
		logic div_done;
	} tsl_sts_t;

	// ln(1+e^-k) in Q0.16
	function automatic logic [15:0] corr_tab(input logic [4:0] k);
		logic [15:0] r;
		case (k)
			5'd0: r = 16'd45426;
			5'd1: r = 16'd20530;
			5'd2: r = 16'd8318;
			5'd3: r = 16'd3184;
			5'd4: r = 16'd1189;
			5'd5: r = 16'd440;
			5'd6: r = 16'd162;
			5'd7: r = 16'd60;
			5'd8: r = 16'd22;
			5'd9: r = 16'd8;
			5'd10: r = 16'd3;
			5'd11: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

/* hdl/triplet_softplus_loss_top.sv */
// Top level of the triplet softplus loss block: controller plus datapath, config register.
// Depends on tsl_pkg, tsl_ctrl, tsl_datapath.
//  channel | signals                          | transaction
//  in      | in_valid, in_ready, in_item      | one vector element of a triplet
//  out     | out_valid, out_ready, out_item   | two losses, batch mean on batch end
//  cfg     | cfg_we, cfg_data                 | write inv_margin
// An element that does not close a triplet is only accumulated.
// A closing element passes ARG1, ARG2, SP2 and CLOSE, plus output handshake; a batch close adds
// DIVLD, the one-bit-per-cycle mean divider and FIN.
// The input stalls while a result waits on out_ready. Reset clears all accumulators.
module triplet_softplus_loss_top import tsl_pkg::*; #(
	parameter int unsigned MAX_TRIPLETS = MaxTripletsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [15:0] cfg_data
);
	logic [15:0] inv_margin_q;
	tsl_cmd_t cmd;
	tsl_sts_t sts;
	logic done_flag;

	// hold config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inv_margin_q <= InvMarginReset;
		else if (cfg_we) inv_margin_q <= cfg_data;
	end

	tsl_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready,
		.last_t(in_item.last_of_triplet), .last_b(in_item.last_of_batch),
		.out_valid, .out_ready, .done_flag, .cmd, .sts
	);

	tsl_datapath #(.MAX_TRIPLETS(MAX_TRIPLETS)) u_dp (
		.clk, .arst_n, .item(in_item), .inv_margin(inv_margin_q), .cmd, .sts,
		.loss_first(out_item.loss_first), .loss_second(out_item.loss_second),
		.batch_loss(out_item.batch_loss)
	);

	assign out_item.batch_done = done_flag;
endmodule

/* hdl/tsl_datapath.sv */
// Datapath: distance accumulators, argument multiplier, softplus, batch total and divider.
// Depends on tsl_pkg.
module tsl_datapath import tsl_pkg::*; #(
	parameter int unsigned MAX_TRIPLETS = MaxTripletsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  logic [15:0] inv_margin,
	input  tsl_cmd_t   cmd,
	output tsl_sts_t   sts,
	output logic [31:0] loss_first,
	output logic [31:0] loss_second,
	output logic [31:0] batch_loss
);
	localparam int CW = $clog2(MAX_TRIPLETS + 1);
	localparam int DW = 48;
	localparam int QW = 6;

	logic [DW-1:0] dp_q, dn1_q, dn2_q, total_q;
	logic [CW-1:0] count_q;
	logic [16:0] dap, dan, dpn;
	logic [16:0] map, man, mpn;
	logic [33:0] sap, san, spn;

	// Element differences and squares
	always_comb begin
		dap = 17'($signed(item.positive_value)) - 17'($signed(item.anchor_value));
		dan = 17'($signed(item.negative_value)) - 17'($signed(item.anchor_value));
		dpn = 17'($signed(item.negative_value)) - 17'($signed(item.positive_value));
		map = dap[16] ? -dap : dap;
		man = dan[16] ? -dan : dan;
		mpn = dpn[16] ? -dpn : dpn;
		sap = 34'(map) * 34'(map);
		san = 34'(man) * 34'(man);
		spn = 34'(mpn) * 34'(mpn);
	end

	function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DW] ? AccMax : s[DW-1:0];
	endfunction

	// Argument: |dp-dn| clamped to 2^40, times inv_margin
	logic [DW-1:0] dn_sel, mag;
	logic          neg;
	logic [40:0]   magc;
	logic [56:0]   prod;
	logic [32:0]   qraw;
	logic signed [16:0] arg;
	logic signed [16:0] arg_q;
	always_comb begin
		dn_sel = cmd.arg_second ? dn2_q : dn1_q;
		neg = dn_sel > dp_q;
		mag = neg ? dn_sel - dp_q : dp_q - dn_sel;
		magc = (mag > 48'h100_0000_0000) ? 41'h100_0000_0000 : mag[40:0];
		prod = 57'(magc) * 57'(inv_margin);
		if (!neg) begin
			qraw = prod[56:24];
			arg = (qraw > 33'd32767) ? 17'sd32767 : $signed({1'b0, qraw[15:0]});
		end else begin
			qraw = 33'((58'(prod) + 58'hFF_FFFF) >> 24);
			arg = (qraw > 33'd32768) ? -17'sd32768 : -$signed({1'b0, qraw[15:0]});
		end
	end

	// Softplus of the registered argument with interpolated correction
	logic [16:0] a_abs;
	logic [15:0] hi, lo, corr;
	logic [23:0] dprod;
	logic [31:0] sp;
	always_comb begin
		a_abs = arg_q[16] ? 17'(-arg_q) : 17'(arg_q);
		hi = corr_tab({1'b0, a_abs[11:8]});
		lo = corr_tab(5'({1'b0, a_abs[11:8]} + 5'd1));
		dprod = 24'(hi - lo) * 24'(a_abs[7:0]);
		corr = (a_abs < 17'd4096) ? 16'(hi - dprod[23:8]) : 16'd0;
		sp = arg_q[16] ? 32'(corr) : ({7'd0, a_abs[15:0], 8'd0} + 32'(corr));
	end

	// Divider: total / (2*count), restoring, one bit per cycle
	logic [DW-1:0] dq_q;
	logic [DW:0]   rem_q;
	logic [CW:0]   dvs_q;
	logic [QW-1:0] dcnt_q;
	logic [DW:0]   trial;
	always_comb trial = {rem_q[DW-1:0], dq_q[DW-1]} - (DW+1)'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q <= '0; dn1_q <= '0; dn2_q <= '0; total_q <= '0; count_q <= '0;
			dcnt_q <= '0; dq_q <= '0; rem_q <= '0; dvs_q <= '0; arg_q <= '0;
			loss_first <= '0; loss_second <= '0; batch_loss <= '0;
		end else begin
			// advance accumulators
			if (cmd.accum) begin
				dp_q  <= sat_add(dp_q, DW'(sap));
				dn1_q <= sat_add(dn1_q, DW'(san));
				dn2_q <= sat_add(dn2_q, DW'(spn));
			end
			if (cmd.arg_first || cmd.arg_second) arg_q <= arg;
			if (cmd.sp_first) loss_first <= sp;
			if (cmd.sp_second) loss_second <= sp;
			if (cmd.close) begin
				dp_q <= '0; dn1_q <= '0; dn2_q <= '0;
				total_q <= sat_add(total_q, DW'(loss_first) + DW'(loss_second));
				if (count_q < CW'(MAX_TRIPLETS)) count_q <= count_q + 1'b1;
				batch_loss <= '0;
			end
			if (cmd.div_start) begin
				dq_q <= total_q;
				rem_q <= '0;
				dvs_q <= {count_q, 1'b0};
				dcnt_q <= QW'(DW);
			end else if (cmd.div_step) begin
				if (!trial[DW]) begin
					rem_q <= trial;
					dq_q <= {dq_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-1:0], dq_q[DW-1]};
					dq_q <= {dq_q[DW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (cmd.batch_clr) begin
				batch_loss <= (dq_q[DW-1:32] != '0) ? 32'hFFFF_FFFF : dq_q[31:0];
				total_q <= '0;
				count_q <= '0;
			end
		end
	end

	assign sts.div_done = (dcnt_q == '0);

endmodule

/* hdl/tsl_ctrl.sv */
// Controller: sequences accumulate, loss, batch-close and divide steps; owns handshakes.
// Depends on tsl_pkg.
module tsl_ctrl import tsl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     last_t,
	input  logic     last_b,
	output logic     out_valid,
	input  logic     out_ready,
	output logic     done_flag,
	output tsl_cmd_t cmd,
	input  tsl_sts_t sts
);
	typedef enum logic [2:0] {IDLE, ARG1, ARG2, SP2, CLOSE, DIV, DIVLD, FIN} state_t;
	state_t state_q;
	logic   batch_q;

	assign in_ready = (state_q == IDLE) && !out_valid;

	// Decode commands from state and the input handshake
	always_comb begin
		cmd = '0;
		cmd.accum = in_valid && in_ready;
		cmd.arg_first = (state_q == ARG1);
		cmd.arg_second = (state_q == ARG2);
		cmd.sp_first = (state_q == ARG2);
		cmd.sp_second = (state_q == SP2);
		cmd.close = (state_q == CLOSE);
		cmd.div_start = (state_q == DIVLD);
		cmd.div_step = (state_q == DIV) && !sts.div_done;
		cmd.batch_clr = (state_q == FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE; batch_q <= 1'b0; out_valid <= 1'b0; done_flag <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				IDLE: if (in_valid && in_ready && last_t) begin
					state_q <= ARG1; batch_q <= last_b;
				end
				ARG1: state_q <= ARG2;
				ARG2: state_q <= SP2;
				SP2: state_q <= CLOSE;
				CLOSE: if (batch_q) state_q <= DIVLD;
					else begin state_q <= IDLE; out_valid <= 1'b1; done_flag <= 1'b0; end
				DIVLD: state_q <= DIV;
				DIV: if (sts.div_done) state_q <= FIN;
				FIN: begin state_q <= IDLE; out_valid <= 1'b1; done_flag <= 1'b1; end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

/* tb/tb.sv */
// Testbench for triplet_softplus_loss_top: directed table, then random triplets and batches.
// Depends on tsl_pkg and the RTL of the block; results are checked against a local predictor.
`timescale 1ns / 100ps

module tb;
	import tsl_pkg::*;

	localparam int unsigned IdleLimit = 4000;
	localparam int unsigned DrainCycles = 80;
	localparam int unsigned TripletCap = 1024;
	localparam logic [63:0] DiffClamp = 64'd1 << 40;
	localparam logic [63:0] OneQ24 = 64'd1 << 24;
	localparam int unsigned CorrTable [0:16] = '{45426, 20530, 8318, 3184, 1189, 440, 162, 60,
		22, 8, 3, 1, 0, 0, 0, 0, 0};

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} table_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_we;
	logic [15:0] cfg_data;

	// predictor state
	logic [15:0] margin_q;
	logic [47:0] dp_acc, dn1_acc, dn2_acc, loss_sum;
	int unsigned trip_cnt;

	out_item_t   loss_queue[$];
	table_row_t  dir_rows[$];
	int unsigned fails;
	int unsigned idle_cycles;
	bit          quiet;
	int unsigned stall_left;

	triplet_softplus_loss_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [47:0] sq_dist(logic signed [15:0] x, logic signed [15:0] y);
		longint d;
		d = longint'(x) - longint'(y);
		if (d < 0) d = -d;
		return 48'(d * d);
	endfunction

	function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? AccMax : s[47:0];
	endfunction

	// scaled distance difference in Q8.8, floor, saturated
	function automatic int scaled_arg(logic [47:0] dp, logic [47:0] dn);
		logic [63:0] mag, prod, q;
		bit neg;
		neg = dn > dp;
		mag = neg ? 64'(dn - dp) : 64'(dp - dn);
		if (mag > DiffClamp) mag = DiffClamp;
		prod = mag * 64'(margin_q);
		if (!neg) begin
			q = prod >> 24;
			return q > 64'd32767 ? 32767 : int'(q);
		end
		q = (prod + OneQ24 - 64'd1) >> 24;
		return q > 64'd32768 ? -32768 : -int'(q);
	endfunction

	function automatic logic [31:0] softplus_loss(int x);
		int unsigned ax, idx, frac, hi, lo, corr;
		ax = x < 0 ? -x : x;
		corr = 0;
		if (ax < 4096) begin
			idx = ax >> 8;
			frac = ax & 255;
			hi = CorrTable[idx];
			lo = CorrTable[idx + 1];
			corr = hi - (((hi - lo) * frac) >> 8);
		end
		if (x >= 0) return 32'(x) * 32'd256 + corr;
		return corr;
	endfunction

	// advance the predictor by one accepted element
	function automatic bit predict_loss(in_item_t it, output out_item_t r);
		logic [63:0] mean;
		r = '0;
		dp_acc = add_sat48(dp_acc, sq_dist(it.positive_value, it.anchor_value));
		dn1_acc = add_sat48(dn1_acc, sq_dist(it.negative_value, it.anchor_value));
		dn2_acc = add_sat48(dn2_acc, sq_dist(it.negative_value, it.positive_value));
		if (!it.last_of_triplet) return 0;
		r.loss_first = softplus_loss(scaled_arg(dp_acc, dn1_acc));
		r.loss_second = softplus_loss(scaled_arg(dp_acc, dn2_acc));
		dp_acc = '0;
		dn1_acc = '0;
		dn2_acc = '0;
		loss_sum = add_sat48(loss_sum, 48'(r.loss_first) + 48'(r.loss_second));
		if (trip_cnt < TripletCap) trip_cnt++;
		if (it.last_of_batch) begin
			mean = 64'(loss_sum) / (64'd2 * 64'(trip_cnt));
			r.batch_loss = mean > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : mean[31:0];
			r.batch_done = 1'b1;
			loss_sum = '0;
			trip_cnt = 0;
		end
		return 1;
	endfunction

	function automatic in_item_t mk_item(int a, int p, int n, bit lt, bit lb);
		in_item_t it;
		it.anchor_value = 16'(a);
		it.positive_value = 16'(p);
		it.negative_value = 16'(n);
		it.last_of_triplet = lt;
		it.last_of_batch = lb;
		return it;
	endfunction

	function automatic void add_row(int a, int p, int n, bit lt, bit lb);
		table_row_t row;
		row.stim = mk_item(a, p, n, lt, lb);
		row.typed = 0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_typed(int a, int p, int n, bit lt, bit lb,
			logic [31:0] l1, logic [31:0] l2, logic [31:0] bl, bit bd);
		table_row_t row;
		row.stim = mk_item(a, p, n, lt, lb);
		row.typed = 1;
		row.want.loss_first = l1;
		row.want.loss_second = l2;
		row.want.batch_loss = bl;
		row.want.batch_done = bd;
		dir_rows.push_back(row);
	endfunction

	// present one element, hold until accepted, queue its result
	task automatic send_elem(in_item_t it, bit typed = 0, out_item_t want = '0);
		out_item_t r;
		int unsigned gap;
		if (!quiet && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (predict_loss(it, r)) loss_queue.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// drop valid and wait for every result plus the block's tail latency
	task automatic drain();
		in_valid <= 1'b0;
		while (loss_queue.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_margin(logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		margin_q = v;
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// one triplet of random content; close_batch sets the batch flag on its last element
	task automatic send_triplet(int unsigned len, bit close_batch);
		logic signed [15:0] base;
		int unsigned spread;
		bit near;
		in_item_t it;
		near = $urandom_range(0, 1);
		spread = $urandom_range(1, 1024);
		for (int unsigned i = 0; i < len; i++) begin
			if (near) begin
				base = 16'($urandom);
				it.anchor_value = base;
				it.positive_value = base + 16'($urandom_range(0, spread));
				it.negative_value = base - 16'($urandom_range(0, spread));
			end else begin
				it.anchor_value = rand_value();
				it.positive_value = rand_value();
				it.negative_value = rand_value();
			end
			it.last_of_triplet = (i == len - 1);
			// stray batch flags mid-triplet are noise
			it.last_of_batch = it.last_of_triplet ? close_batch : ($urandom_range(0, 9) == 0);
			send_elem(it);
		end
	endtask

	// receiver: random stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (loss_queue.size() == 0) begin
				$error("unexpected result transaction");
				fails++;
			end else begin
				want = loss_queue.pop_front();
				if (out_item.loss_first !== want.loss_first) begin
					$error("loss_first: expected %0d, actual %0d", want.loss_first,
						out_item.loss_first);
					fails++;
				end
				if (out_item.loss_second !== want.loss_second) begin
					$error("loss_second: expected %0d, actual %0d", want.loss_second,
						out_item.loss_second);
					fails++;
				end
				if (out_item.batch_loss !== want.batch_loss) begin
					$error("batch_loss: expected %0d, actual %0d", want.batch_loss,
						out_item.batch_loss);
					fails++;
				end
				if (out_item.batch_done !== want.batch_done) begin
					$error("batch_done: expected %0d, actual %0d", want.batch_done,
						out_item.batch_done);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		in_item_t it;
		int unsigned sent;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		fails = 0;
		idle_cycles = 0;
		quiet = 0;
		stall_left = 0;
		margin_q = InvMarginReset;
		dp_acc = '0;
		dn1_acc = '0;
		dn2_acc = '0;
		loss_sum = '0;
		trip_cnt = 0;

		// directed table: extremes, batch flag alone, zero distances
		add_typed(0, 0, 0, 1, 1, 45426, 45426, 45426, 1);
		add_typed(32767, 32767, -32768, 1, 0, 0, 0, 0, 0);
		add_typed(-32768, 32767, -32768, 1, 1, 8388352, 45426, 2108444, 1);
		add_row(100, -5, 3, 0, 1);
		add_row(-1, 1, 0, 0, 0);
		add_row(1234, -4321, 777, 1, 0);
		add_row(-32768, -32768, -32768, 1, 1);
		add_row(16'h5555, 16'hAAAA, 16'h5555, 0, 0);
		add_row(16'hAAAA, 16'h5555, 16'hAAAA, 1, 0);
		add_row(40, 41, 43, 1, 0);
		add_row(-700, -690, -650, 0, 0);
		add_row(-700, -705, -640, 1, 0);
		add_row(4096, 4200, 3000, 1, 1);
		add_row(0, 300, 100, 1, 1);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the table at the reset margin, then at the margin extremes
		foreach (dir_rows[i]) send_elem(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
		write_margin(16'd0);
		for (int i = 5; i < dir_rows.size(); i++) send_elem(dir_rows[i].stim);
		write_margin(16'hFFFF);
		for (int i = 5; i < dir_rows.size(); i++) send_elem(dir_rows[i].stim);
		write_margin(16'd1);
		for (int i = 5; i < dir_rows.size(); i++) send_elem(dir_rows[i].stim);

		// long vector of maximal distances
		write_margin(InvMarginReset);
		for (int unsigned i = 0; i < 300; i++) begin
			it = mk_item(32767, -32768, 32767, i == 299, 1);
			send_elem(it);
		end

		// long batch: triplet count saturates
		for (int unsigned i = 0; i < 1030; i++) send_triplet(1, i == 1029);

		// random phases with random margins
		sent = 0;
		while (sent < 500) begin
			case ($urandom_range(0, 5))
				0: write_margin(16'd1);
				1: write_margin(16'hFFFF);
				2: write_margin(16'd0);
				default: write_margin(16'($urandom_range(1, 2048)));
			endcase
			for (int t = $urandom_range(4, 30); t > 0; t--) begin
				automatic int unsigned len = $urandom_range(0, 7) == 0 ?
					$urandom_range(9, 40) : $urandom_range(1, 6);
				quiet = sent > 400;
				send_triplet(len, $urandom_range(0, 5) == 0 || t == 1);
				sent += len;
			end
		end

		drain();
		if (fails == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
